### rtl/core/cie_pkg.sv
// Shared types and codes of the cumulative incidence unit.
// Used by cie_smalldiv and cumulative_incidence_euler_unit; depends on nothing.
package cie_pkg;

	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 3;

	localparam logic [CfgIndexWidth-1:0] CFG_CAUSE_INDEX     = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_INDEX_FROM_ONE  = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_MISSING_AS_ZERO = 2'd2;

	localparam logic [1:0] ERR_OK         = 2'd0;
	localparam logic [1:0] ERR_BAD_DT     = 2'd1;
	localparam logic [1:0] ERR_NEG_HAZARD = 2'd2;
	localparam logic [1:0] ERR_CAUSE      = 2'd3;

	// Series length of the fractional exponential and integer part limit.
	localparam int          ExpTerms = 16;
	localparam logic [15:0] ExpIntLimit = 16'd23;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TERM_SET,
		ST_MUL,
		ST_DIV_START,
		ST_DIV,
		ST_TERM_ACC,
		ST_FRAC_END,
		ST_E1_USE,
		ST_EXP_START,
		ST_POW,
		ST_POW_USE,
		ST_P_SET,
		ST_P_USE,
		ST_I_USE,
		ST_Q_USE
	} st_t;

	typedef struct packed {
		logic        start;
		logic [32:0] dividend;
		logic [4:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quotient;
	} div_rsp_t;

endpackage

### rtl/core/cie_smalldiv.sv
// Divider of a 33-bit value by a 5-bit divisor, eight quotient bits a cycle.
// Depends on cie_pkg for the request and response structs.
module cie_smalldiv (
	input  logic               clk,
	input  logic               arst_n,
	input  cie_pkg::div_req_t  req,
	output cie_pkg::div_rsp_t  rsp
);

	localparam int PadWidth = 40;

	logic [PadWidth-1:0] buf_q;
	logic [PadWidth-1:0] quot_q;
	logic [4:0]          rem_q;
	logic [4:0]          div_q;
	logic [2:0]          cnt_q;
	logic                active_q;
	logic                done_q;
	logic [4:0]          rem_c;
	logic [7:0]          qbits_c;

	always_comb begin
		logic [5:0] r6;
		rem_c   = rem_q;
		qbits_c = '0;
		for (int i = 0; i < 8; i++) begin
			r6 = {rem_c, buf_q[PadWidth-1-i]};
			if (r6 >= {1'b0, div_q}) begin
				r6 = r6 - {1'b0, div_q};
				qbits_c[7-i] = 1'b1;
			end
			rem_c = r6[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			buf_q  <= {7'b0, req.dividend};
			div_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (active_q) begin
			buf_q  <= {buf_q[PadWidth-9:0], 8'b0};
			rem_q  <= rem_c;
			quot_q <= {quot_q[PadWidth-9:0], qbits_c};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q[32:0];

endmodule

### rtl/core/cumulative_incidence_euler_unit.sv
// Top level of the cumulative incidence unit: sequencer around one shared multiplier.
// Depends on cie_pkg and cie_smalldiv.
//
//  channel | signals                        | transfer when
//  --------+--------------------------------+----------------------------
//  config  | cfg_write cfg_index cfg_data   | cfg_write high
//  input   | in_valid in_stall + row fields | in_valid high, in_stall low
//  output  | out_valid out_stall + results  | out_valid high, out_stall low
//
// An error row or a poisoned row finishes in check. A computed row with n (integer
// part of -log survival) below 23 sums sixteen series terms (setup, multiply, divide
// wait) and raises e^-1 to the power n; when n is 23 or more it skips both.
// Every row returns to idle. The first computed row after reset also computes the e^-1
// factor. in_stall is low only in idle; a finished row waits while the output register
// is held under out_stall.
module cumulative_incidence_euler_unit #(
	parameter int NUM_CAUSES = 4,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [cie_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [cie_pkg::CfgDataWidth-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       subject_id,
	input  logic signed [31:0]                interval_length,
	input  logic                              interval_missing,
	input  logic signed [31:0]                hazard_a,
	input  logic signed [31:0]                hazard_b,
	input  logic signed [31:0]                hazard_c,
	input  logic signed [31:0]                hazard_d,
	input  logic [3:0]                        hazard_missing,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       incidence,
	output logic                              incidence_missing,
	output logic [1:0]                        error_code
);

	localparam int          NCols = (NUM_CAUSES < 4) ? NUM_CAUSES : 4;
	localparam int          ShP   = 2 * FRAC_BITS - 31;
	localparam int          ShQ   = 2 * FRAC_BITS - 32;
	localparam logic [63:0] CapP  = 64'hFFFF_FFFF;
	localparam logic [63:0] CapQ  = 64'h0000_8000_0000_0000;
	localparam logic [47:0] LogCap = 48'h8000_0000_0000;
	localparam logic [32:0] OneQ32 = 33'h1_0000_0000;

	function automatic logic [63:0] rescale(input logic [63:0] p, input int sh,
		input logic [63:0] cap);
		logic [63:0] v;
		if (sh >= 0) begin
			v = p >> sh;
		end else begin
			if ((p >> (64 + sh)) != 64'd0) return cap;
			v = p << (-sh);
		end
		return (v > cap) ? cap : v;
	endfunction

	cie_pkg::st_t state_q, state_d;
	cie_pkg::st_t ret_q;

	// configuration
	logic [2:0] cause_q;
	logic       from_one_q;
	logic       maz_q;

	// subject state
	logic [31:0] last_q;
	logic        first_q;
	logic [47:0] mag_q;
	logic [31:0] inc_q;
	logic        poison_q;
	logic        e1_valid_q;

	// row and working registers
	logic [31:0] id_q;
	logic [30:0] dt_q;
	logic        interval_neg_q;
	logic        dtmiss_q;
	logic [31:0] haz_q [4];
	logic [3:0]  hmiss_q;
	logic [30:0] hc_q;
	logic [32:0] hsum_q;
	logic [33:0] ma_q, mb_q;
	logic [67:0] prod_q;
	logic [31:0] f_q;
	logic [32:0] t_q;
	logic signed [35:0] s_q;
	logic [4:0]  k_q;
	logic        mode_e1_q;
	logic [32:0] r_q;
	logic [32:0] e1_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] out_inc_q;
	logic        out_miss_q;
	logic [1:0]  out_err_q;

	cie_pkg::div_req_t div_req;
	cie_pkg::div_rsp_t div_rsp;

	logic        accept;
	logic        newsub_c;
	logic        any_miss_c;
	logic        neg_c;
	logic [2:0]  tgt_c;
	logic        tgt_bad_c;
	logic [1:0]  err_c;
	logic        poison_c;
	logic [30:0] hc_c;
	logic [32:0] hsum_c;
	logic [32:0] s_clamp_c;
	logic [63:0] p_wide_c;
	logic [63:0] q_wide_c;
	logic [31:0] p_c;
	logic [32:0] inc_sum_c;
	logic [47:0] q_c;
	logic        finish_c;
	logic        load_out;

	assign accept = in_valid && !in_stall;

	always_comb begin
		if (from_one_q) begin
			tgt_c     = cause_q - 3'd1;
			tgt_bad_c = (cause_q == 3'd0) || (32'(tgt_c) >= NCols);
		end else begin
			tgt_c     = cause_q;
			tgt_bad_c = 32'(tgt_c) >= NCols;
		end
		any_miss_c = 1'b0;
		neg_c      = 1'b0;
		hc_c       = '0;
		hsum_c     = '0;
		for (int j = 0; j < NCols; j++) begin
			if (hmiss_q[j]) begin
				any_miss_c = 1'b1;
			end else begin
				neg_c  = neg_c | haz_q[j][31];
				hsum_c = hsum_c + {2'b0, haz_q[j][30:0]};
				if (32'(tgt_c) == j) hc_c = haz_q[j][30:0];
			end
		end
		priority if (tgt_bad_c)                    err_c = cie_pkg::ERR_CAUSE;
		else if (dtmiss_q || interval_neg_q)       err_c = cie_pkg::ERR_BAD_DT;
		else if (neg_c)                            err_c = cie_pkg::ERR_NEG_HAZARD;
		else                                       err_c = cie_pkg::ERR_OK;
		newsub_c = first_q || (id_q != last_q);
		poison_c = (newsub_c ? 1'b0 : poison_q) | (any_miss_c & !maz_q);
	end

	always_comb begin
		if (s_q < 0)                            s_clamp_c = '0;
		else if (s_q > $signed({3'b0, OneQ32})) s_clamp_c = OneQ32;
		else                                    s_clamp_c = s_q[32:0];
		p_wide_c  = rescale(prod_q[63:0], ShP, CapP);
		q_wide_c  = rescale(prod_q[63:0], ShQ, CapQ);
		p_c       = p_wide_c[31:0];
		q_c       = q_wide_c[47:0];
		inc_sum_c = {1'b0, inc_q} + {1'b0, prod_q[63:32]};
	end

	// next state
	always_comb begin
		state_d  = state_q;
		finish_c = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q[64:32];
		div_req.divisor  = k_q;
		unique case (state_q)
			cie_pkg::ST_IDLE: if (accept) state_d = cie_pkg::ST_CHECK;
			cie_pkg::ST_CHECK: begin
				if (err_c != cie_pkg::ERR_OK || poison_c) begin
					finish_c = 1'b1;
				end else if (!e1_valid_q) begin
					state_d = cie_pkg::ST_TERM_SET;
				end else begin
					state_d = cie_pkg::ST_EXP_START;
				end
			end
			cie_pkg::ST_TERM_SET: state_d = cie_pkg::ST_MUL;
			cie_pkg::ST_MUL: state_d = ret_q;
			cie_pkg::ST_DIV_START: begin
				div_req.start = 1'b1;
				state_d = cie_pkg::ST_DIV;
			end
			cie_pkg::ST_DIV: if (div_rsp.done) state_d = cie_pkg::ST_TERM_ACC;
			cie_pkg::ST_TERM_ACC: begin
				state_d = (32'(k_q) == cie_pkg::ExpTerms) ? cie_pkg::ST_FRAC_END
					: cie_pkg::ST_TERM_SET;
			end
			cie_pkg::ST_FRAC_END: state_d = mode_e1_q ? cie_pkg::ST_MUL : cie_pkg::ST_POW;
			cie_pkg::ST_E1_USE: state_d = cie_pkg::ST_EXP_START;
			cie_pkg::ST_EXP_START: begin
				state_d = (mag_q[47:32] >= cie_pkg::ExpIntLimit) ? cie_pkg::ST_P_SET
					: cie_pkg::ST_TERM_SET;
			end
			cie_pkg::ST_POW: state_d = (cnt_q == 5'd0) ? cie_pkg::ST_P_SET : cie_pkg::ST_MUL;
			cie_pkg::ST_POW_USE: state_d = cie_pkg::ST_POW;
			cie_pkg::ST_P_SET: state_d = cie_pkg::ST_MUL;
			cie_pkg::ST_P_USE: state_d = cie_pkg::ST_MUL;
			cie_pkg::ST_I_USE: state_d = cie_pkg::ST_MUL;
			cie_pkg::ST_Q_USE: finish_c = 1'b1;
			default: state_d = cie_pkg::ST_IDLE;
		endcase
		// hold the finished row until the output register is free
		if (finish_c) state_d = load_out ? cie_pkg::ST_IDLE : state_q;
	end

	assign load_out = (!out_valid_q || !out_stall)
		&& (state_q == cie_pkg::ST_Q_USE || (state_q == cie_pkg::ST_CHECK
		&& (err_c != cie_pkg::ERR_OK || poison_c)));
	assign in_stall = state_q != cie_pkg::ST_IDLE;

	cie_smalldiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cie_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, subject state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cause_q     <= 3'd1;
			from_one_q  <= 1'b1;
			maz_q       <= 1'b0;
			last_q      <= '0;
			first_q     <= 1'b1;
			mag_q       <= '0;
			inc_q       <= '0;
			poison_q    <= 1'b0;
			e1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					cie_pkg::CFG_CAUSE_INDEX:     cause_q    <= cfg_data;
					cie_pkg::CFG_INDEX_FROM_ONE:  from_one_q <= cfg_data[0];
					cie_pkg::CFG_MISSING_AS_ZERO: maz_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == cie_pkg::ST_CHECK && err_c == cie_pkg::ERR_OK && load_out
				|| state_q == cie_pkg::ST_CHECK && err_c == cie_pkg::ERR_OK && !poison_c) begin
				if (newsub_c) begin
					last_q  <= id_q;
					first_q <= 1'b0;
					mag_q   <= '0;
					inc_q   <= '0;
				end
				poison_q <= poison_c;
			end
			if (state_q == cie_pkg::ST_E1_USE) e1_valid_q <= 1'b1;
			if (state_q == cie_pkg::ST_I_USE) begin
				inc_q <= inc_sum_c[32] ? 32'hFFFF_FFFF : inc_sum_c[31:0];
			end
			if (state_q == cie_pkg::ST_Q_USE && load_out) begin
				mag_q <= (q_c >= LogCap - mag_q) ? LogCap : mag_q + q_c;
			end
			if (load_out)            out_valid_q <= 1'b1;
			else if (!out_stall)     out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q           <= subject_id;
			dt_q           <= interval_length[30:0];
			interval_neg_q <= interval_length[31];
			dtmiss_q       <= interval_missing;
			haz_q[0]       <= hazard_a;
			haz_q[1]       <= hazard_b;
			haz_q[2]       <= hazard_c;
			haz_q[3]       <= hazard_d;
			hmiss_q        <= hazard_missing;
		end
		unique case (state_q)
			cie_pkg::ST_CHECK: begin
				hc_q      <= hc_c;
				hsum_q    <= hsum_c;
				f_q       <= 32'h8000_0000;
				t_q       <= OneQ32;
				s_q       <= $signed({3'b0, OneQ32});
				k_q       <= 5'd1;
				mode_e1_q <= 1'b1;
				ret_q     <= cie_pkg::ST_DIV_START;
			end
			cie_pkg::ST_TERM_SET: begin
				ma_q  <= {1'b0, t_q};
				mb_q  <= {2'b0, f_q};
				ret_q <= cie_pkg::ST_DIV_START;
			end
			cie_pkg::ST_MUL: prod_q <= ma_q * mb_q;
			cie_pkg::ST_DIV: if (div_rsp.done) t_q <= div_rsp.quotient;
			cie_pkg::ST_TERM_ACC: begin
				if (k_q[0]) s_q <= s_q - $signed({3'b0, t_q});
				else        s_q <= s_q + $signed({3'b0, t_q});
				k_q <= k_q + 5'd1;
			end
			cie_pkg::ST_FRAC_END: begin
				r_q   <= s_clamp_c;
				ma_q  <= {1'b0, s_clamp_c};
				mb_q  <= {1'b0, s_clamp_c};
				ret_q <= cie_pkg::ST_E1_USE;
			end
			cie_pkg::ST_E1_USE: e1_q <= prod_q[64:32];
			cie_pkg::ST_EXP_START: begin
				if (mag_q[47:32] >= cie_pkg::ExpIntLimit) r_q <= '0;
				f_q       <= mag_q[31:0];
				t_q       <= OneQ32;
				s_q       <= $signed({3'b0, OneQ32});
				k_q       <= 5'd1;
				mode_e1_q <= 1'b0;
				cnt_q     <= mag_q[36:32];
			end
			cie_pkg::ST_POW: begin
				ma_q  <= {1'b0, r_q};
				mb_q  <= {1'b0, e1_q};
				ret_q <= cie_pkg::ST_POW_USE;
			end
			cie_pkg::ST_POW_USE: begin
				r_q   <= prod_q[64:32];
				cnt_q <= cnt_q - 5'd1;
			end
			cie_pkg::ST_P_SET: begin
				ma_q  <= {3'b0, hc_q};
				mb_q  <= {3'b0, dt_q};
				ret_q <= cie_pkg::ST_P_USE;
			end
			cie_pkg::ST_P_USE: begin
				ma_q  <= {1'b0, r_q};
				mb_q  <= {2'b0, p_c};
				ret_q <= cie_pkg::ST_I_USE;
			end
			cie_pkg::ST_I_USE: begin
				ma_q  <= {1'b0, hsum_q};
				mb_q  <= {3'b0, dt_q};
				ret_q <= cie_pkg::ST_Q_USE;
			end
			default: ;
		endcase
		if (load_out) begin
			if (state_q == cie_pkg::ST_Q_USE) begin
				out_inc_q  <= inc_q;
				out_miss_q <= 1'b0;
				out_err_q  <= cie_pkg::ERR_OK;
			end else begin
				out_inc_q  <= '0;
				out_miss_q <= 1'b1;
				out_err_q  <= err_c;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign incidence         = out_inc_q;
	assign incidence_missing = out_miss_q;
	assign error_code        = out_err_q;

endmodule
